### design/sacl_pkg.sv
// Shared types and constants for the set-associative LRU read cache.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sacl_pkg;

    // fixed field widths of the stream words
    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 2;
    localparam int STAMP_W = 32;
    localparam int LINE_W  = 64;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 32;

    // access size codes; any other code reads a word
    localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_HALF = 2'd1;
    localparam logic [SIZE_W-1:0] SZ_WORD = 2'd2;

    // controller to datapath: one strobe per datapath step
    typedef struct packed {
        logic clr;   // write a cleared row during the post-reset sweep
        logic load;  // capture the input word
        logic div1;  // block number
        logic div2;  // offset and tag
        logic div3;  // set index
        logic rd;    // read the set row
        logic cmp;   // tag compare, free way search
        logic scan;  // one step of the LRU victim scan
        logic wr;    // write back the row, load the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // last row of the clearing sweep
        logic need_scan;  // miss with every way valid and more than one way
        logic scan_last;  // scan is at the last way
        logic out_free;   // result register can take a new word
    } t_dp_sts;

endpackage

`default_nettype wire

### design/set_assoc_cache_lru_read.sv
// Top level of the read-only set-associative cache with timestamp LRU.
// Depends on sacl_pkg, sacl_ctrl, sacl_dp (which holds sacl_ram).
//
// One read request is taken per input word while the block is ready; a
// word passes through the address split (three stages of constant-reciprocal
// multiplies for block number, offset and tag, and set), the registered read
// of the set row from the single row RAM, the tag compare, on a miss into a
// full set the LRU victim scan, which steps one way per cycle, and the
// write-back, which waits for room in the output register. The result sits
// in an output register and the next request is accepted while it waits to
// be taken. After reset the row RAM is cleared one set per cycle, during
// which no request is accepted.
`default_nettype none

module set_assoc_cache_lru_read
    import sacl_pkg::*;
#(
    parameter int NUM_SETS    = 4,
    parameter int NUM_WAYS    = 2,
    parameter int BLOCK_BYTES = 8,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // request stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [111:0] i_s_tdata,   // address[15:0], now_stamp[31:0], fill_block[63:0]
    input  wire logic [1:0]   i_s_tuser,   // access_size[1:0]
    // result stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [103:0]      o_m_tdata,   // read_data[31:0], way_used, hits_so_far[31:0],
                                           // misses_so_far[31:0], zero pad[6:0]
    output logic [0:0]        o_m_tuser    // hit
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    logic [DATA_W-1:0]  read_data;
    logic               hit;
    logic               way_used;
    logic [COUNT_W-1:0] hits_so_far;
    logic [COUNT_W-1:0] misses_so_far;

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sacl_dp #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_address       (i_s_tdata[15:0]),
        .i_access_size   (i_s_tuser),
        .i_now_stamp     (i_s_tdata[47:16]),
        .i_fill_block    (i_s_tdata[111:48]),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_read_data     (read_data),
        .o_hit           (hit),
        .o_way_used      (way_used),
        .o_hits_so_far   (hits_so_far),
        .o_misses_so_far (misses_so_far)
    );

    // result word packing
    assign o_m_tdata = {7'd0, misses_so_far, hits_so_far, way_used, read_data};
    assign o_m_tuser = hit;

endmodule

`default_nettype wire

### design/sacl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/sacl_ctrl.sv
// Sequencer of the LRU read cache: clearing sweep, address split, row read,
// compare, victim scan and write-back. Depends on sacl_pkg.
`default_nettype none

module sacl_ctrl
    import sacl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [8:0] {
        ST_CLR  = 9'b000000001,
        ST_IDLE = 9'b000000010,
        ST_DIV1 = 9'b000000100,
        ST_DIV2 = 9'b000001000,
        ST_DIV3 = 9'b000010000,
        ST_RD   = 9'b000100000,
        ST_CMP  = 9'b001000000,
        ST_SCAN = 9'b010000000,
        ST_WR   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command strobes
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV1;
                end
            end
            ST_DIV1: begin
                o_cmd.div1 = 1'b1;
                n_state    = ST_DIV2;
            end
            ST_DIV2: begin
                o_cmd.div2 = 1'b1;
                n_state    = ST_DIV3;
            end
            ST_DIV3: begin
                o_cmd.div3 = 1'b1;
                n_state    = ST_RD;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.need_scan ? ST_SCAN : ST_WR;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                // wait for room in the result register
                if (i_sts.out_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### design/sacl_dp.sv
// Datapath of the LRU read cache: address split, set row RAM, tag compare,
// victim scan, byte extraction, counters and result register.
// Depends on sacl_pkg and sacl_ram.
`default_nettype none

module sacl_dp
    import sacl_pkg::*;
#(
    parameter int NUM_SETS    = 4,
    parameter int NUM_WAYS    = 2,
    parameter int BLOCK_BYTES = 8,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic [ADDR_W-1:0]  i_address,
    input  wire logic [SIZE_W-1:0]  i_access_size,
    input  wire logic [STAMP_W-1:0] i_now_stamp,
    input  wire logic [LINE_W-1:0]  i_fill_block,
    input  wire logic               i_m_tready,
    output logic                    o_m_tvalid,
    output logic [DATA_W-1:0]       o_read_data,
    output logic                    o_hit,
    output logic                    o_way_used,
    output logic [COUNT_W-1:0]      o_hits_so_far,
    output logic [COUNT_W-1:0]      o_misses_so_far
);

    // used address bits and value ranges
    localparam int EA   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int AMAX = (1 << EA) - 1;
    localparam int BMAX = AMAX / BLOCK_BYTES;
    localparam int TMAX = BMAX / NUM_SETS;
    localparam int BW   = (BMAX > 0) ? $clog2(BMAX + 1) : 1;
    localparam int TW   = (TMAX > 0) ? $clog2(TMAX + 1) : 1;
    localparam int OW   = $clog2(BLOCK_BYTES);
    localparam int SW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    // reciprocals: floor(n/D) = (n*M) >> S, exact for every n in range
    localparam int L1 = $clog2(BLOCK_BYTES);
    localparam int S1 = EA + L1;
    localparam int M1 = ((1 << S1) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int P1 = S1 + BW + 1;
    localparam int L2 = $clog2(NUM_SETS);
    localparam int S2 = BW + L2;
    localparam int M2 = ((1 << S2) + NUM_SETS - 1) / NUM_SETS;
    localparam int P2 = S2 + TW + 1;

    // row layout: one entry per way, valid in the low bit
    localparam int F_TAG   = 1;
    localparam int F_STAMP = F_TAG + TW;
    localparam int F_DATA  = F_STAMP + STAMP_W;
    localparam int EW      = F_DATA + LINE_W;
    localparam int RW      = NUM_WAYS * EW;

    // bytes a line really holds
    localparam int LIM = (BLOCK_BYTES < 8) ? BLOCK_BYTES : 8;

    // captured request
    logic [EA-1:0]      r_addr;
    logic [SIZE_W-1:0]  r_size;
    logic [STAMP_W-1:0] r_now;
    logic [LINE_W-1:0]  r_fill;

    // split address
    logic [BW-1:0] r_blk;
    logic [OW-1:0] r_off;
    logic [TW-1:0] r_tag;
    logic [SW-1:0] r_set;

    // lookup result and scan state
    logic               r_hit;
    logic [WW-1:0]      r_way;
    logic [STAMP_W-1:0] r_best_stamp;
    logic [WW-1:0]      r_scan;
    logic [SW-1:0]      r_clr;

    // counters and result register
    logic [COUNT_W-1:0] r_hits;
    logic [COUNT_W-1:0] r_misses;
    logic               r_ovalid;
    logic [DATA_W-1:0]  r_odata;
    logic               r_ohit;
    logic               r_oway;

    logic [P1-1:0] prod1;
    logic [P2-1:0] prod2;
    logic [EA-1:0] off_diff;
    logic [BW-1:0] set_diff;

    logic [RW-1:0]      row;
    logic [RW-1:0]      n_row;
    logic [EW-1:0]      n_entry;
    logic               way_v  [NUM_WAYS];
    logic [TW-1:0]      way_tg [NUM_WAYS];
    logic [STAMP_W-1:0] way_st [NUM_WAYS];
    logic [LINE_W-1:0]  way_dt [NUM_WAYS];
    logic               any_hit;
    logic               any_inv;
    logic [WW-1:0]      hit_idx;
    logic [WW-1:0]      inv_idx;
    logic [STAMP_W-1:0] scan_st;

    logic [LINE_W-1:0]  src_line;
    logic [7:0]         line_byte [8];
    logic [2:0]         nbytes;
    logic [OW:0]        pos [4];
    logic [DATA_W-1:0]  n_data;

    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata;

    // address split arithmetic
    always_comb begin
        prod1    = P1'(r_addr) * P1'(M1);
        off_diff = r_addr - EA'(r_blk) * EA'(BLOCK_BYTES);
        prod2    = P2'(r_blk) * P2'(M2);
        set_diff = r_blk - BW'(r_tag) * BW'(NUM_SETS);
    end

    // unpack the set row
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            way_v[w]  = row[w*EW];
            way_tg[w] = row[w*EW + F_TAG +: TW];
            way_st[w] = row[w*EW + F_STAMP +: STAMP_W];
            way_dt[w] = row[w*EW + F_DATA +: LINE_W];
        end
    end

    // tag compare and free way search, lowest way wins
    always_comb begin
        any_hit = 1'b0;
        any_inv = 1'b0;
        hit_idx = '0;
        inv_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (way_v[w] && (way_tg[w] == r_tag)) begin
                any_hit = 1'b1;
                hit_idx = WW'(w);
            end
            if (!way_v[w]) begin
                any_inv = 1'b1;
                inv_idx = WW'(w);
            end
        end
    end

    assign scan_st = way_st[r_scan];

    // byte extraction from the hit line or the fill block
    always_comb begin
        src_line = r_hit ? way_dt[r_way] : r_fill;
        for (int b = 0; b < 8; b++) begin
            line_byte[b] = src_line[8*b +: 8];
        end
        case (r_size)
            SZ_BYTE: nbytes = 3'd1;
            SZ_HALF: nbytes = 3'd2;
            default: nbytes = 3'd4;
        endcase
        n_data = '0;
        for (int k = 0; k < 4; k++) begin
            pos[k] = (OW + 1)'(r_off) + (OW + 1)'(k);
            if ((3'(k) < nbytes) && (pos[k] < (OW + 1)'(LIM))) begin
                n_data[8*k +: 8] = line_byte[pos[k][2:0]];
            end
        end
    end

    // updated row for write-back
    always_comb begin
        if (r_hit) begin
            n_entry = {way_dt[r_way], r_now, way_tg[r_way], 1'b1};
        end else begin
            n_entry = {r_fill, r_now, r_tag, 1'b1};
        end
        n_row = row;
        n_row[r_way*EW +: EW] = n_entry;
    end

    // RAM write: clearing sweep or write-back
    always_comb begin
        ram_we    = i_cmd.clr | i_cmd.wr;
        ram_waddr = i_cmd.clr ? r_clr : r_set;
        ram_wdata = i_cmd.clr ? '0 : n_row;
    end

    sacl_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_set),
        .o_rdata (row)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_address[EA-1:0];
            r_size <= i_access_size;
            r_now  <= i_now_stamp;
            r_fill <= i_fill_block;
        end
        if (i_cmd.div1) begin
            r_blk <= prod1[S1 +: BW];
        end
        if (i_cmd.div2) begin
            r_off <= OW'(off_diff);
            r_tag <= prod2[S2 +: TW];
        end
        if (i_cmd.div3) begin
            r_set <= SW'(set_diff);
        end
        if (i_cmd.cmp) begin
            r_hit        <= any_hit;
            r_way        <= any_hit ? hit_idx : (any_inv ? inv_idx : '0);
            r_best_stamp <= way_st[0];
            r_scan       <= WW'(1);
        end
        if (i_cmd.scan) begin
            // strictly smaller stamp replaces the candidate
            if (scan_st < r_best_stamp) begin
                r_best_stamp <= scan_st;
                r_way        <= r_scan;
            end
            r_scan <= r_scan + WW'(1);
        end
        if (i_cmd.wr) begin
            r_odata <= n_data;
            r_ohit  <= r_hit;
            r_oway  <= r_way[0];
        end
    end

    // control registers: sweep index, counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cmd.wr) begin
                r_ovalid <= 1'b1;
                if (r_hit) begin
                    r_hits <= r_hits + COUNT_W'(1);
                end else begin
                    r_misses <= r_misses + COUNT_W'(1);
                end
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // status
    always_comb begin
        o_sts.clr_last  = (r_clr == SW'(NUM_SETS - 1));
        o_sts.need_scan = (NUM_WAYS > 1) && !any_hit && !any_inv;
        o_sts.scan_last = (r_scan == WW'(NUM_WAYS - 1));
        o_sts.out_free  = !r_ovalid || i_m_tready;
    end

    assign o_m_tvalid      = r_ovalid;
    assign o_read_data     = r_odata;
    assign o_hit           = r_ohit;
    assign o_way_used      = r_oway;
    assign o_hits_so_far   = r_hits;
    assign o_misses_so_far = r_misses;

endmodule

`default_nettype wire
